>>> rtl/c_comment_and_whitespace_stripper_defines.svh
// Assertion helpers shared by the stripper RTL.
`ifndef C_COMMENT_AND_WHITESPACE_STRIPPER_DEFINES_SVH
`define C_COMMENT_AND_WHITESPACE_STRIPPER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define CCWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define CCWS_ASSERT_NEVER(label, cond, msg) \
   `CCWS_ASSERT(label, !(cond), msg)

`endif

>>> rtl/ccws_pkg.sv
// ----------------------------------------------------------------------------
// ccws_pkg
// Shared types and character codes for the comment and whitespace stripper.
// ----------------------------------------------------------------------------
package ccws_pkg;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int unsigned SEL_W       = $clog2(MAX_RESULTS);

   localparam logic [6:0] CH_NUL    = 7'h00;
   localparam logic [6:0] CH_TAB    = 7'h09;
   localparam logic [6:0] CH_LF     = 7'h0A;
   localparam logic [6:0] CH_FF     = 7'h0C;
   localparam logic [6:0] CH_CR     = 7'h0D;
   localparam logic [6:0] CH_SPACE  = 7'h20;
   localparam logic [6:0] CH_DQUOTE = 7'h22;
   localparam logic [6:0] CH_HASH   = 7'h23;
   localparam logic [6:0] CH_SQUOTE = 7'h27;
   localparam logic [6:0] CH_STAR   = 7'h2A;
   localparam logic [6:0] CH_SLASH  = 7'h2F;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_DEL    = 7'h7F;

   // Results caused by one input word, queued between front and back.
   typedef struct packed {
      logic [CNT_W-1:0]                count;
      logic                            stream_end;
      logic [MAX_RESULTS-1:0][6:0]     bytes;
   } grp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/ccws_if.sv
// ----------------------------------------------------------------------------
// ccws_if
// Valid/ready channels for source text in and stripped text out.
// ----------------------------------------------------------------------------
interface ccws_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] in_byte;
   logic       stream_end;

   modport source (output valid, output in_byte, output stream_end, input ready);
   modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface ccws_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_byte;
   logic       run_last;
   logic       stream_done;

   modport source (output valid, output out_byte, output run_last, output stream_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input stream_done,
                   output ready);
endinterface

>>> rtl/ccws_front.sv
// ----------------------------------------------------------------------------
// ccws_front
// Scanner: takes one word per cycle unless the queue is full, tracks comment
// and quote modes, squeezes whitespace and pushes result groups to the queue.
// ----------------------------------------------------------------------------
`include "c_comment_and_whitespace_stripper_defines.svh"

module ccws_front
   import ccws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   ccws_req_if.sink       req,
   input  q_status_type   q_status,
   output logic           push,
   output grp_entry_type  push_entry
);

   typedef struct packed {
      logic [6:0] la_byte;
      logic       la_valid;
      logic       in_comment;
      logic       in_string;
      logic       in_char;
      logic       in_directive;
      logic       after_escape;
      logic       after_break;
      logic [6:0] held;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      logic           consumed;
      grp_entry_type  acc;
   } work_type;

   localparam scan_state_type STATE_RESET = '{
      la_byte: CH_NUL, la_valid: 1'b0, in_comment: 1'b0, in_string: 1'b0,
      in_char: 1'b0, in_directive: 1'b0, after_escape: 1'b0,
      after_break: 1'b1, held: CH_NUL};

   scan_state_type state_ff, state_in;
   grp_entry_type  entry;
   logic           accept;
   logic           end_accept;
   logic           scan_at_reset;

   function automatic work_type add_byte(work_type w, logic [6:0] b);
      w.acc.bytes[w.acc.count[SEL_W-1:0]] = b;
      w.acc.count = w.acc.count + CNT_W'(1);
      return w;
   endfunction

   function automatic work_type squeeze(work_type w, logic [6:0] c);
      logic ws;
      ws = (c <= CH_SPACE || c == CH_DEL) && !w.st.in_string && !w.st.in_char;
      if (w.st.held != CH_NUL) begin
         if (!ws) begin
            w = add_byte(w, w.st.held);
            w = add_byte(w, c);
            w.st.held = CH_NUL;
         end else if (c == CH_LF || c == CH_CR || c == CH_FF) begin
            w.st.held = CH_LF;
         end else if (c == CH_TAB && w.st.held != CH_LF) begin
            w.st.held = CH_TAB;
         end else if (c == CH_SPACE && w.st.held != CH_LF && w.st.held != CH_TAB) begin
            w.st.held = CH_SPACE;
         end
      end else if (ws) begin
         w.st.held = (c == CH_CR || c == CH_FF) ? CH_LF : c;
      end else begin
         w = add_byte(w, c);
      end
      return w;
   endfunction

   // Process one character; consumed flags that the next byte was eaten too.
   function automatic work_type handle(work_type w, logic [6:0] c, logic has_next,
                                       logic [6:0] nxt);
      logic was;
      was = w.st.in_comment;
      case (c)
         CH_HASH: begin
            if (w.st.after_break && !w.st.in_comment) w.st.in_directive = 1'b1;
         end
         CH_LF: begin
            if (!w.st.after_escape) begin
               w.st.in_directive = 1'b0;
               w.st.in_char      = 1'b0;
               w.st.in_string    = 1'b0;
            end
         end
         CH_SLASH: begin
            if (!w.st.in_string && !w.st.in_char && has_next && nxt == CH_STAR)
               w.st.in_comment = 1'b1;
         end
         CH_STAR: begin
            if (w.st.in_comment && has_next && nxt == CH_SLASH)
               w.st.in_comment = 1'b0;
         end
         CH_SQUOTE: begin
            if (!w.st.in_comment && !w.st.after_escape && !w.st.in_string)
               w.st.in_char = !w.st.in_char;
         end
         CH_DQUOTE: begin
            if (!w.st.in_comment && !w.st.after_escape && !w.st.in_char)
               w.st.in_string = !w.st.in_string;
         end
         default: begin
         end
      endcase
      w.st.after_escape = !w.st.after_escape && (c == CH_BSLASH);
      w.st.after_break  = !w.st.after_escape && (c == CH_LF);
      if (!w.st.in_comment && !was) w = squeeze(w, c);
      w.consumed = (w.st.in_comment != was);
      return w;
   endfunction

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      work_type w;
      w.st        = state_ff;
      w.consumed  = 1'b0;
      w.acc       = '0;
      if (state_ff.la_valid) begin
         w = handle(w, state_ff.la_byte, 1'b1, req.in_byte);
         if (w.consumed) begin
            w.st.la_valid = 1'b0;
         end else begin
            w.st.la_byte = req.in_byte;
         end
      end else begin
         w.st.la_byte  = req.in_byte;
         w.st.la_valid = 1'b1;
      end
      // Drain lookahead and held whitespace, then go back to reset.
      if (req.stream_end) begin
         if (w.st.la_valid) w = handle(w, w.st.la_byte, 1'b0, CH_NUL);
         if (w.st.held != CH_NUL) w = add_byte(w, w.st.held);
         w.st = STATE_RESET;
      end
      w.acc.stream_end = req.stream_end;
      state_in = w.st;
      entry    = w.acc;
   end

   assign push       = accept && (entry.count != '0);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign end_accept    = accept && req.stream_end;
   assign scan_at_reset = !state_ff.la_valid && state_ff.after_break && state_ff.held == CH_NUL;

   `CCWS_ASSERT(a_end_restarts, end_accept |=> scan_at_reset, "scanner not reset after stream end")
   `CCWS_ASSERT_NEVER(a_push_overfull, push && q_status.full, "push while queue full")

endmodule

>>> rtl/ccws_queue.sv
// ----------------------------------------------------------------------------
// ccws_queue
// Small register queue of result groups between scanner and output side.
// ----------------------------------------------------------------------------
`include "c_comment_and_whitespace_stripper_defines.svh"

module ccws_queue
   import ccws_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  grp_entry_type  push_entry,
   input  logic           pop,
   output grp_entry_type  head_entry,
   output q_status_type   q_status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   grp_entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_entry     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CCWS_ASSERT_NEVER(a_pop_empty, pop && q_status.empty, "pop from empty queue")
   `CCWS_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

>>> rtl/ccws_back.sv
// ----------------------------------------------------------------------------
// ccws_back
// Output side: takes one result group from the queue and sends its characters
// one word per cycle while ready, marking the last of the group and stream.
// ----------------------------------------------------------------------------
`include "c_comment_and_whitespace_stripper_defines.svh"

module ccws_back
   import ccws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  grp_entry_type  head_entry,
   input  q_status_type   q_status,
   output logic           pop,
   ccws_rsp_if.source     rsp
);

   grp_entry_type     cur_ff;
   logic              cur_valid_ff, cur_valid_in;
   logic [SEL_W-1:0]  idx_ff, idx_in;
   logic              fire;
   logic              last;
   logic              group_ok;

   assign last = ({1'b0, idx_ff} == CNT_W'(cur_ff.count - CNT_W'(1)));
   assign fire = rsp.valid && rsp.ready;

   assign rsp.valid       = cur_valid_ff;
   assign rsp.out_byte    = cur_ff.bytes[idx_ff];
   assign rsp.run_last    = last;
   assign rsp.stream_done = last && cur_ff.stream_end;

   // Load the next group when idle or when the current one finishes.
   assign pop = (!cur_valid_ff || (fire && last)) && !q_status.empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (fire) begin
         if (last) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_entry;
      end
   end

   assign group_ok = cur_ff.count != '0 && cur_ff.count <= CNT_W'(MAX_RESULTS)
                     && {1'b0, idx_ff} < cur_ff.count;

   `CCWS_ASSERT(a_group_nonempty, cur_valid_ff |-> group_ok, "output group index out of range")

endmodule

>>> rtl/c_comment_and_whitespace_stripper.sv
// Results are registered in the group queue, then in the back end's group register.
// Throughput: one input word per cycle while the output side keeps up; the output
// side sends one word per cycle, so a word causing several results (stream end
// drain, held whitespace plus a character) slows intake once the group queue fills.
// Reset: synchronous; clears scanner modes and lookahead, empties the group queue.
// ----------------------------------------------------------------------------
// c_comment_and_whitespace_stripper
// Streaming C block comment remover with whitespace squeeze: scanner front,
// group queue, serializing back end.
// ----------------------------------------------------------------------------
module c_comment_and_whitespace_stripper
   import ccws_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   ccws_req_if.sink   req_if,
   ccws_rsp_if.source rsp_if
);

   q_status_type  q_status;
   logic          push;
   logic          pop;
   grp_entry_type push_entry;
   grp_entry_type head_entry;

   ccws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   ccws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   ccws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule
